@@ src/text_console_glyph_renderer_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the text console glyph renderer
// Concurrent assertion helpers; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_ASSERT_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define TCGR_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tcgr assertion failed");
// Next-cycle implication, checked outside reset.
`define TCGR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tcgr assertion failed");
`else
`define TCGR_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define TCGR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ src/tcgr_pkg.sv @@
// ----------------------------------------------------------------------------
// Text console glyph renderer package
// Shared constants, register codes and transaction types.
// ----------------------------------------------------------------------------
package tcgr_pkg;

  localparam int GLYPH_ROWS      = 16;
  localparam int FONT_SLOTS      = 256;
  localparam int MAX_SCREEN_DIM  = 4096;

  localparam int GLYPH_WIDTH     = 8;
  localparam int FIRST_PRINTABLE = 32'h20;
  localparam int EXTENDED_BASE   = 128;
  localparam int NEWLINE_CODE    = 10;

  localparam int CODE_W   = 8;
  localparam int COLOR_W  = 32;
  localparam int GROW_W   = 4;
  localparam int BITS_W   = 8;
  localparam int INDEX_W  = 25;
  localparam int MASK_W   = GLYPH_WIDTH;
  localparam int DIM_W    = 13;
  localparam int COL_W    = 13;
  localparam int ROW_W    = $clog2(MAX_SCREEN_DIM);
  localparam int Y_W      = $clog2(MAX_SCREEN_DIM + GLYPH_ROWS);
  localparam int RCNT_W   = $clog2(GLYPH_ROWS);

  localparam int STORE_DEPTH = FONT_SLOTS * GLYPH_ROWS;
  localparam int FONT_AW     = $clog2(STORE_DEPTH);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DIM_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_PITCH_PIXELS  = 2'd2,
    REG_ENABLED       = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic                 mode;
    logic [CODE_W-1:0]    char_code;
    logic [COLOR_W-1:0]   color;
    logic [GROW_W-1:0]    glyph_row;
    logic [BITS_W-1:0]    row_bits;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0]   pixel_index;
    logic [MASK_W-1:0]    pixel_mask;
    logic [COLOR_W-1:0]   pixel_color;
    logic                 last_row;
  } out_item_t;

  typedef struct packed {
    logic [DIM_W-1:0]     screen_width;
    logic [DIM_W-1:0]     screen_height;
    logic [DIM_W-1:0]     pitch_pixels;
    logic                 enabled;
  } cfg_t;

  // One character to draw, as handed from the front end to the row engine.
  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [COL_W-1:0]     col;
    logic [CODE_W-1:0]    slot;
    logic                 have_glyph;
    logic [COLOR_W-1:0]   color;
  } render_cmd_t;

  typedef struct packed {
    logic                 en;
    logic [FONT_AW-1:0]   addr;
    logic [BITS_W-1:0]    data;
  } font_wr_t;

  typedef struct packed {
    logic                 en;
    logic [FONT_AW-1:0]   addr;
  } font_rd_t;

endpackage

@@ src/tcgr_in_if.sv @@
// ----------------------------------------------------------------------------
// Input channel interface
// Valid/ready channel carrying character and font-load transactions.
// ----------------------------------------------------------------------------
interface tcgr_in_if;
  logic                 valid;
  logic                 ready;
  tcgr_pkg::in_item_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/tcgr_out_if.sv @@
// ----------------------------------------------------------------------------
// Output channel interface
// Valid/ready channel carrying framebuffer row-write transactions.
// ----------------------------------------------------------------------------
interface tcgr_out_if;
  logic                 valid;
  logic                 ready;
  tcgr_pkg::out_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/tcgr_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Configuration write interface
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface tcgr_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [tcgr_pkg::CFG_IDX_W-1:0]     index;
  logic [tcgr_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/tcgr_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module tcgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ src/tcgr_queue.sv @@
// ----------------------------------------------------------------------------
// Render command queue
// Short FIFO that decouples the front end from the row engine.
// ----------------------------------------------------------------------------
module tcgr_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  tcgr_pkg::render_cmd_t  push_cmd_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output logic                   valid_o,
  output tcgr_pkg::render_cmd_t  cmd_o
);

  tcgr_pkg::render_cmd_t            mem_q [tcgr_pkg::QUEUE_DEPTH];
  logic [tcgr_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [tcgr_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [tcgr_pkg::QPTR_W:0]        count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == tcgr_pkg::QPTR_W'(tcgr_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == tcgr_pkg::QPTR_W'(tcgr_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  assign full_o  = (count_q == (tcgr_pkg::QPTR_W + 1)'(tcgr_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

endmodule

@@ src/tcgr_front.sv @@
// ----------------------------------------------------------------------------
// Renderer front end
// Accepts transactions, loads the font, tracks the cursor, queues characters.
// ----------------------------------------------------------------------------
module tcgr_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  tcgr_in_if.sink                in_i,
  input  tcgr_pkg::cfg_t         cfg_i,
  input  logic                   q_full_i,
  input  logic                   drain_busy_i,
  output logic                   push_o,
  output tcgr_pkg::render_cmd_t  push_cmd_o,
  output tcgr_pkg::font_wr_t     font_wr_o
);

  logic [tcgr_pkg::COL_W-1:0]   col_q, col_d;
  logic [tcgr_pkg::ROW_W-1:0]   row_q, row_d;
  logic [tcgr_pkg::ROW_W:0]     row_plus;
  logic [tcgr_pkg::ROW_W-1:0]   row_down;
  logic [tcgr_pkg::COL_W:0]     col_adv;
  logic [tcgr_pkg::COL_W+1:0]   col_reach;
  logic                         wrap;
  logic                         is_load, is_nl, accept;
  logic [tcgr_pkg::CODE_W-1:0]  code, slot;
  logic                         have_glyph;

  assign code    = in_i.data.char_code;
  assign is_load = in_i.data.mode;
  assign is_nl   = (32'(code) == tcgr_pkg::NEWLINE_CODE);

  // A font load waits until every queued character has read the font, so
  // that glyph data is always taken in transaction order.
  assign in_i.ready = !q_full_i && !(is_load && drain_busy_i);
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    if (32'(code) < tcgr_pkg::FIRST_PRINTABLE) begin
      slot       = '0;
      have_glyph = 1'b0;
    end else begin
      slot       = (32'(code) < tcgr_pkg::EXTENDED_BASE) ?
                   code - tcgr_pkg::CODE_W'(tcgr_pkg::FIRST_PRINTABLE) : code;
      have_glyph = (32'(slot) < tcgr_pkg::FONT_SLOTS);
    end
  end

  // One glyph line down, saturating at the bottom of the coordinate range.
  assign row_plus = (tcgr_pkg::ROW_W + 1)'(row_q) +
                    (tcgr_pkg::ROW_W + 1)'(tcgr_pkg::GLYPH_ROWS);
  assign row_down = (row_plus > (tcgr_pkg::ROW_W + 1)'(tcgr_pkg::MAX_SCREEN_DIM - 1)) ?
                    tcgr_pkg::ROW_W'(tcgr_pkg::MAX_SCREEN_DIM - 1) :
                    row_plus[tcgr_pkg::ROW_W-1:0];

  assign col_adv   = (tcgr_pkg::COL_W + 1)'(col_q) +
                     (tcgr_pkg::COL_W + 1)'(tcgr_pkg::GLYPH_WIDTH);
  assign col_reach = (tcgr_pkg::COL_W + 2)'(col_adv) +
                     (tcgr_pkg::COL_W + 2)'(tcgr_pkg::GLYPH_WIDTH);
  assign wrap      = (col_reach > (tcgr_pkg::COL_W + 2)'(cfg_i.screen_width));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept && !is_load) begin
      if (is_nl || wrap) begin
        col_d = '0;
        row_d = row_down;
      end else begin
        col_d = col_adv[tcgr_pkg::COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign push_o                = accept && !is_load && !is_nl;
  assign push_cmd_o.row        = row_q;
  assign push_cmd_o.col        = col_q;
  assign push_cmd_o.slot       = slot;
  assign push_cmd_o.have_glyph = have_glyph;
  assign push_cmd_o.color      = in_i.data.color;

  assign font_wr_o.en   = accept && is_load &&
                          (32'(code) < tcgr_pkg::FONT_SLOTS) &&
                          (32'(in_i.data.glyph_row) < tcgr_pkg::GLYPH_ROWS);
  assign font_wr_o.addr = tcgr_pkg::FONT_AW'(32'(code) * tcgr_pkg::GLYPH_ROWS +
                                            32'(in_i.data.glyph_row));
  assign font_wr_o.data = in_i.data.row_bits;

endmodule

@@ src/tcgr_back.sv @@
// ----------------------------------------------------------------------------
// Renderer row engine
// Walks the glyph rows of each queued character and emits row writes.
// ----------------------------------------------------------------------------
module tcgr_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tcgr_pkg::cfg_t                 cfg_i,
  input  logic                           q_valid_i,
  input  tcgr_pkg::render_cmd_t          q_cmd_i,
  output logic                           pop_o,
  output tcgr_pkg::font_rd_t             font_rd_o,
  input  logic [tcgr_pkg::BITS_W-1:0]    font_data_i,
  output logic                           busy_o,
  tcgr_out_if.source                     out_o
);

  // Issue stage: the character being walked and its row counter.
  logic                           a_busy_q;
  tcgr_pkg::render_cmd_t          cmd_q;
  logic [tcgr_pkg::RCNT_W-1:0]    rcnt_q;
  logic                           a_last;

  // Mask stage: one row whose font byte arrives from the RAM.
  logic                           b_valid_q;
  logic [tcgr_pkg::Y_W-1:0]       b_y_q;
  logic [tcgr_pkg::COL_W-1:0]     b_col_q;
  logic [tcgr_pkg::COLOR_W-1:0]   b_color_q;
  logic                           b_have_q;
  logic                           b_last_q;

  logic                           out_valid_q;
  tcgr_pkg::out_item_t            out_q, out_d;

  logic                           advance;
  logic [tcgr_pkg::MASK_W-1:0]    clip;
  logic                           y_ok;
  logic [tcgr_pkg::Y_W+tcgr_pkg::DIM_W-1:0] prod;

  assign advance = !out_valid_q || out_o.ready;
  assign a_last  = (rcnt_q == tcgr_pkg::RCNT_W'(tcgr_pkg::GLYPH_ROWS - 1));
  assign pop_o   = advance && (!a_busy_q || a_last) && q_valid_i;
  assign busy_o  = a_busy_q || b_valid_q;

  assign font_rd_o.en   = advance && a_busy_q;
  assign font_rd_o.addr = tcgr_pkg::FONT_AW'(32'(cmd_q.slot) * tcgr_pkg::GLYPH_ROWS +
                                            32'(rcnt_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_busy_q    <= 1'b0;
      rcnt_q      <= '0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      b_valid_q   <= a_busy_q;
      out_valid_q <= b_valid_q;
      if (pop_o) begin
        a_busy_q <= 1'b1;
        rcnt_q   <= '0;
      end else if (a_busy_q && a_last) begin
        a_busy_q <= 1'b0;
      end else if (a_busy_q) begin
        rcnt_q <= rcnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= q_cmd_i;
    end
    if (advance) begin
      b_y_q     <= tcgr_pkg::Y_W'(cmd_q.row) + tcgr_pkg::Y_W'(rcnt_q);
      b_col_q   <= cmd_q.col;
      b_color_q <= cmd_q.color;
      b_have_q  <= cmd_q.have_glyph;
      b_last_q  <= a_last;
      out_q     <= out_d;
    end
  end

  // Clear mask bits whose pixel column falls at or beyond the screen edge.
  always_comb begin
    for (int px = 0; px < tcgr_pkg::GLYPH_WIDTH; px++) begin
      clip[tcgr_pkg::MASK_W-1-px] = (32'(b_col_q) + px < 32'(cfg_i.screen_width));
    end
  end

  assign y_ok = (32'(b_y_q) < 32'(cfg_i.screen_height));
  assign prod = (tcgr_pkg::Y_W + tcgr_pkg::DIM_W)'(b_y_q) *
                (tcgr_pkg::Y_W + tcgr_pkg::DIM_W)'(cfg_i.pitch_pixels);

  always_comb begin
    out_d.pixel_index = tcgr_pkg::INDEX_W'(prod +
                        (tcgr_pkg::Y_W + tcgr_pkg::DIM_W)'(b_col_q));
    out_d.pixel_mask  = (b_have_q && cfg_i.enabled && y_ok) ?
                        (font_data_i & clip) : '0;
    out_d.pixel_color = b_color_q;
    out_d.last_row    = b_last_q;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

@@ src/text_console_glyph_renderer.sv @@
// An accepted character passes through the queue, the issue stage and the mask stage
//   to the output register before its first row write leaves. Row writes go out one per
//   cycle while the sink accepts them, as the row engine walks the glyph rows through the single font memory read port.
// Newlines and font loads bypass the queue; a font load waits until queued work drains.
// Reset clears the cursor, queue and pipeline and restores the register defaults; the
//   font memory is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
// Text console glyph renderer
// Draws 8-pixel-wide bitmap glyphs as framebuffer row-write transactions.
// ----------------------------------------------------------------------------
`include "text_console_glyph_renderer_assert.svh"

module text_console_glyph_renderer (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcgr_in_if.sink     in_i,
  tcgr_cfg_if.sink    cfg_i,
  tcgr_out_if.source  out_o
);

  // The design splits into a front end and a row engine. The front end takes
  // each input transaction as it is accepted: font loads go straight into the font
  // memory, newlines only move the cursor, and every other character is
  // turned into a render command (cursor position, glyph slot, colour) and
  // pushed into a two-entry queue while the cursor advances. The row engine
  // pops commands and walks the glyph rows, reading one font byte per cycle,
  // clipping it and forming the framebuffer pixel index. An output register
  // sits at the end, so the engine keeps going as long as the sink takes data.

  tcgr_pkg::cfg_t         cfg_q;

  logic                   q_push, q_full, q_pop, q_valid;
  tcgr_pkg::render_cmd_t  q_push_cmd, q_cmd;
  tcgr_pkg::font_wr_t     font_wr;
  tcgr_pkg::font_rd_t     font_rd;
  logic [tcgr_pkg::BITS_W-1:0] font_data;
  logic                   back_busy;
  logic                   drain_busy;
  logic                   load_acc, render_acc;

  // Configuration registers. Writes are always taken; software must change them
  // only while the renderer is idle, with no check for this in the block, so no shadowing is needed.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width  <= tcgr_pkg::DIM_W'(1024);
      cfg_q.screen_height <= tcgr_pkg::DIM_W'(768);
      cfg_q.pitch_pixels  <= tcgr_pkg::DIM_W'(1024);
      cfg_q.enabled       <= 1'b0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (tcgr_pkg::cfg_reg_e'(cfg_i.index))
        tcgr_pkg::REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_i.data;
        tcgr_pkg::REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_i.data;
        tcgr_pkg::REG_PITCH_PIXELS:  cfg_q.pitch_pixels  <= cfg_i.data;
        tcgr_pkg::REG_ENABLED:       cfg_q.enabled       <= cfg_i.data[0];
        default: begin
        end
      endcase
    end
  end

  // Anything still waiting to read the font holds back a font load.
  assign drain_busy = q_valid || back_busy;

  tcgr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_q),
    .q_full_i     (q_full),
    .drain_busy_i (drain_busy),
    .push_o       (q_push),
    .push_cmd_o   (q_push_cmd),
    .font_wr_o    (font_wr)
  );

  tcgr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .cmd_o      (q_cmd)
  );

  // Font memory: one glyph row per entry, slot-major.
  tcgr_ram #(
    .WIDTH (tcgr_pkg::BITS_W),
    .DEPTH (tcgr_pkg::STORE_DEPTH)
  ) u_font_ram (
    .clk_i     (clk_i),
    .wr_en_i   (font_wr.en),
    .wr_addr_i (font_wr.addr),
    .wr_data_i (font_wr.data),
    .rd_en_i   (font_rd.en),
    .rd_addr_i (font_rd.addr),
    .rd_data_o (font_data)
  );

  tcgr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .pop_o       (q_pop),
    .font_rd_o   (font_rd),
    .font_data_i (font_data),
    .busy_o      (back_busy),
    .out_o       (out_o)
  );

  // Checks on the queue handshake between the two halves and on font-load
  // ordering against characters still in flight.
  assign load_acc   = in_i.valid && in_i.ready && in_i.data.mode;
  assign render_acc = in_i.valid && in_i.ready && !in_i.data.mode &&
                      (32'(in_i.data.char_code) != tcgr_pkg::NEWLINE_CODE);

  `TCGR_ASSERT_IMPL(a_push_has_room, clk_i, rst_ni, q_push, !q_full)
  `TCGR_ASSERT_IMPL(a_pop_has_entry, clk_i, rst_ni, q_pop, q_valid)
  `TCGR_ASSERT_IMPL(a_load_after_drain, clk_i, rst_ni, load_acc, !drain_busy)
  `TCGR_ASSERT_NEXT(a_render_in_flight, clk_i, rst_ni, render_acc, drain_busy)

endmodule
